>>> hdl/thermal_alarm_controller_defines.svh
// Assertion macros shared by the thermal alarm controller checkers.
`ifndef THERMAL_ALARM_CONTROLLER_DEFINES_SVH
`define THERMAL_ALARM_CONTROLLER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TAC_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define TAC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

>>> hdl/tac_pkg.sv
// Types and constants of the thermal alarm controller.
package tac_pkg;

    // Field widths.
    localparam int SAMPLE_BITS = 10;
    localparam int THRESH_W    = 10;
    localparam int TIME_W      = 12;
    localparam int CHAR_W      = 7;
    localparam int CMD_W       = 2;
    localparam int APB_ADDR_W  = 5;
    localparam int APB_DATA_W  = 32;
    localparam int WINDOW_LEN  = 4;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CHAR   = 2'd2;

    // Register indexes (byte address divided by four).
    localparam logic [2:0] REG_ALARM_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_NORMAL_ON       = 3'd1;
    localparam logic [2:0] REG_NORMAL_OFF      = 3'd2;
    localparam logic [2:0] REG_ALARM_ON        = 3'd3;
    localparam logic [2:0] REG_ALARM_OFF       = 3'd4;
    localparam logic [2:0] REG_SAMPLE_BUDGET   = 3'd5;

    // Register reset values.
    localparam logic [THRESH_W-1:0] RST_ALARM_THRESHOLD = 10'd735;
    localparam logic [TIME_W-1:0]   RST_NORMAL_ON       = 12'd500;
    localparam logic [TIME_W-1:0]   RST_NORMAL_OFF      = 12'd1500;
    localparam logic [TIME_W-1:0]   RST_ALARM_ON        = 12'd200;
    localparam logic [TIME_W-1:0]   RST_ALARM_OFF       = 12'd300;
    localparam logic [TIME_W-1:0]   RST_SAMPLE_BUDGET   = 12'd1500;

    // Acknowledge sequence, oldest character first.
    localparam logic [CHAR_W-1:0] CH_A    = 7'h41;
    localparam logic [CHAR_W-1:0] CH_C    = 7'h63;
    localparam logic [CHAR_W-1:0] CH_K    = 7'h6B;
    localparam logic [CHAR_W-1:0] CH_BANG = 7'h21;

    typedef struct packed {
        logic [CMD_W-1:0]       cmd;
        logic [SAMPLE_BITS-1:0] sample;
        logic [CHAR_W-1:0]      rx_char;
    } tac_item_t;

    typedef struct packed {
        logic                   alarm;
        logic                   led_green;
        logic                   led_red;
        logic                   send_warning;
        logic                   sampling_on;
        logic [SAMPLE_BITS-1:0] average;
    } tac_result_t;

    typedef struct packed {
        logic [THRESH_W-1:0] alarm_threshold;
        logic [TIME_W-1:0]   normal_on_ms;
        logic [TIME_W-1:0]   normal_off_ms;
        logic [TIME_W-1:0]   alarm_on_ms;
        logic [TIME_W-1:0]   alarm_off_ms;
        logic [TIME_W-1:0]   sample_budget;
    } tac_cfg_t;

endpackage

>>> hdl/tac_cfg_regs.sv
// APB register file holding the controller's configuration.
module tac_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tac_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tac_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tac_pkg::APB_DATA_W-1:0] prdata,
    output tac_pkg::tac_cfg_t              cfg
);

    tac_pkg::tac_cfg_t cfg_reg;
    tac_pkg::tac_cfg_t cfg_next;
    logic [2:0]        reg_index;
    logic              wr_en;

    assign reg_index = paddr[tac_pkg::APB_ADDR_W-1:2];
    assign wr_en     = psel && penable && pwrite;

    // Decode a write into the addressed register.
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_index)
                tac_pkg::REG_ALARM_THRESHOLD:
                    cfg_next.alarm_threshold = pwdata[tac_pkg::THRESH_W-1:0];
                tac_pkg::REG_NORMAL_ON:     cfg_next.normal_on_ms  = pwdata[tac_pkg::TIME_W-1:0];
                tac_pkg::REG_NORMAL_OFF:    cfg_next.normal_off_ms = pwdata[tac_pkg::TIME_W-1:0];
                tac_pkg::REG_ALARM_ON:      cfg_next.alarm_on_ms   = pwdata[tac_pkg::TIME_W-1:0];
                tac_pkg::REG_ALARM_OFF:     cfg_next.alarm_off_ms  = pwdata[tac_pkg::TIME_W-1:0];
                tac_pkg::REG_SAMPLE_BUDGET: cfg_next.sample_budget = pwdata[tac_pkg::TIME_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.alarm_threshold <= tac_pkg::RST_ALARM_THRESHOLD;
            cfg_reg.normal_on_ms    <= tac_pkg::RST_NORMAL_ON;
            cfg_reg.normal_off_ms   <= tac_pkg::RST_NORMAL_OFF;
            cfg_reg.alarm_on_ms     <= tac_pkg::RST_ALARM_ON;
            cfg_reg.alarm_off_ms    <= tac_pkg::RST_ALARM_OFF;
            cfg_reg.sample_budget   <= tac_pkg::RST_SAMPLE_BUDGET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Read-back multiplexer; unmapped addresses read as zero.
    always_comb begin
        prdata = '0;
        unique case (reg_index)
            tac_pkg::REG_ALARM_THRESHOLD:
                prdata = {{(tac_pkg::APB_DATA_W-tac_pkg::THRESH_W){1'b0}}, cfg_reg.alarm_threshold};
            tac_pkg::REG_NORMAL_ON:
                prdata = {{(tac_pkg::APB_DATA_W-tac_pkg::TIME_W){1'b0}}, cfg_reg.normal_on_ms};
            tac_pkg::REG_NORMAL_OFF:
                prdata = {{(tac_pkg::APB_DATA_W-tac_pkg::TIME_W){1'b0}}, cfg_reg.normal_off_ms};
            tac_pkg::REG_ALARM_ON:
                prdata = {{(tac_pkg::APB_DATA_W-tac_pkg::TIME_W){1'b0}}, cfg_reg.alarm_on_ms};
            tac_pkg::REG_ALARM_OFF:
                prdata = {{(tac_pkg::APB_DATA_W-tac_pkg::TIME_W){1'b0}}, cfg_reg.alarm_off_ms};
            tac_pkg::REG_SAMPLE_BUDGET:
                prdata = {{(tac_pkg::APB_DATA_W-tac_pkg::TIME_W){1'b0}}, cfg_reg.sample_budget};
            default: prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

>>> hdl/tac_core.sv
// Controller state and the single-pass update applied to each item.
module tac_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance,
    input  tac_pkg::tac_item_t    item,
    input  tac_pkg::tac_cfg_t     cfg,
    output tac_pkg::tac_result_t  result
);

    logic                            alarm_mode_reg, alarm_mode_next;
    logic                            phase_on_reg, phase_on_next;
    logic [tac_pkg::TIME_W-1:0]      elapsed_reg, elapsed_next;
    logic [1:0]                      warn_count_reg, warn_count_next;
    logic [tac_pkg::SAMPLE_BITS-1:0] prev_sample_reg, prev_sample_next;
    logic [tac_pkg::TIME_W-1:0]      samples_left_reg, samples_left_next;
    logic                            sampling_reg, sampling_next;
    logic [tac_pkg::SAMPLE_BITS-1:0] last_avg_reg, last_avg_next;
    logic [tac_pkg::CHAR_W-1:0]      window_reg [tac_pkg::WINDOW_LEN];
    logic [tac_pkg::CHAR_W-1:0]      window_next [tac_pkg::WINDOW_LEN];
    logic                            warn;

    logic [tac_pkg::TIME_W-1:0]      dur_raw;
    logic [tac_pkg::TIME_W-1:0]      dur;
    logic                            phase_done;
    logic [tac_pkg::SAMPLE_BITS:0]   sample_sum;
    logic [tac_pkg::SAMPLE_BITS-1:0] avg;
    logic                            over_threshold;
    logic [tac_pkg::TIME_W-1:0]      samples_dec;
    logic                            ack_seen;

    // Duration of the current LED phase; zero behaves as one.
    assign dur_raw = alarm_mode_reg ? (phase_on_reg ? cfg.alarm_on_ms : cfg.alarm_off_ms)
                                    : (phase_on_reg ? cfg.normal_on_ms : cfg.normal_off_ms);
    assign dur = (dur_raw == '0) ? tac_pkg::TIME_W'(1) : dur_raw;
    assign phase_done = ({1'b0, elapsed_reg} + (tac_pkg::TIME_W+1)'(1)) >= {1'b0, dur};

    // Two-sample average and the threshold compare.
    assign sample_sum     = {1'b0, item.sample} + {1'b0, prev_sample_reg};
    assign avg            = sample_sum[tac_pkg::SAMPLE_BITS:1];
    assign over_threshold = avg > cfg.alarm_threshold;
    assign samples_dec    = (samples_left_reg != '0) ? samples_left_reg - tac_pkg::TIME_W'(1)
                                                     : samples_left_reg;

    // The window after shifting in the character reads the acknowledge text.
    assign ack_seen = (window_reg[1] == tac_pkg::CH_A) && (window_reg[2] == tac_pkg::CH_C) &&
                      (window_reg[3] == tac_pkg::CH_K) && (item.rx_char == tac_pkg::CH_BANG);

    // Next state for the item in the input register.
    always_comb begin
        alarm_mode_next   = alarm_mode_reg;
        phase_on_next     = phase_on_reg;
        elapsed_next      = elapsed_reg;
        warn_count_next   = warn_count_reg;
        prev_sample_next  = prev_sample_reg;
        samples_left_next = samples_left_reg;
        sampling_next     = sampling_reg;
        last_avg_next     = last_avg_reg;
        window_next       = window_reg;
        warn              = 1'b0;
        unique case (item.cmd)
            tac_pkg::CMD_TICK: begin
                if (phase_done) begin
                    phase_on_next = !phase_on_reg;
                    elapsed_next  = '0;
                    if (alarm_mode_reg) begin
                        if (warn_count_reg == 2'd3) begin
                            warn            = 1'b1;
                            warn_count_next = '0;
                        end else begin
                            warn_count_next = warn_count_reg + 2'd1;
                        end
                    end
                end else begin
                    elapsed_next = elapsed_reg + tac_pkg::TIME_W'(1);
                end
            end
            tac_pkg::CMD_SAMPLE: begin
                if (!alarm_mode_reg && sampling_reg) begin
                    prev_sample_next = item.sample;
                    last_avg_next    = avg;
                    if (over_threshold) begin
                        alarm_mode_next = 1'b1;
                        phase_on_next   = 1'b1;
                        elapsed_next    = '0;
                        warn_count_next = '0;
                    end else begin
                        samples_left_next = samples_dec;
                        if (samples_dec == '0) begin
                            sampling_next = 1'b0;
                        end
                    end
                end
            end
            tac_pkg::CMD_CHAR: begin
                if (alarm_mode_reg) begin
                    window_next[0] = window_reg[1];
                    window_next[1] = window_reg[2];
                    window_next[2] = window_reg[3];
                    window_next[3] = item.rx_char;
                    if (ack_seen) begin
                        alarm_mode_next   = 1'b0;
                        phase_on_next     = 1'b1;
                        elapsed_next      = '0;
                        samples_left_next = cfg.sample_budget;
                        sampling_next     = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // State registers advance only when the item moves to the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alarm_mode_reg   <= 1'b0;
            phase_on_reg     <= 1'b1;
            elapsed_reg      <= '0;
            warn_count_reg   <= '0;
            prev_sample_reg  <= '0;
            samples_left_reg <= tac_pkg::RST_SAMPLE_BUDGET;
            sampling_reg     <= 1'b1;
            last_avg_reg     <= '0;
            for (int i = 0; i < tac_pkg::WINDOW_LEN; i++) begin
                window_reg[i] <= '0;
            end
        end else if (advance) begin
            alarm_mode_reg   <= alarm_mode_next;
            phase_on_reg     <= phase_on_next;
            elapsed_reg      <= elapsed_next;
            warn_count_reg   <= warn_count_next;
            prev_sample_reg  <= prev_sample_next;
            samples_left_reg <= samples_left_next;
            sampling_reg     <= sampling_next;
            last_avg_reg     <= last_avg_next;
            window_reg       <= window_next;
        end
    end

    // Result fields reflect the state after the update.
    always_comb begin
        result.alarm        = alarm_mode_next;
        result.led_green    = !alarm_mode_next && phase_on_next;
        result.led_red      = alarm_mode_next && phase_on_next;
        result.send_warning = warn;
        result.sampling_on  = !alarm_mode_next && sampling_next;
        result.average      = last_avg_next;
    end

endmodule

>>> hdl/thermal_alarm_controller.sv
// Top level of the thermal alarm controller: handshake registers and submodules.
//
//   Channel   Direction  Payload         Transfer when
//   s_        in         tac_item_t      s_valid && s_ready
//   m_        out        tac_result_t    m_valid && m_ready
//   APB       in/out     32-bit regs     psel && penable && pready
//
// One item per cycle sustained while m_ready stays high; a taken transfer passes through
// the input register and then the result register before it shows on m_valid and m_data.
// Synchronous active-low reset restores register and state defaults; no clear pass.
// A stalled result register holds the input register, and s_ready falls only
// while both are full and m_ready is low.
module thermal_alarm_controller (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  tac_pkg::tac_item_t             s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output tac_pkg::tac_result_t           m_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tac_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tac_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tac_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    logic                 in_valid_reg;
    tac_pkg::tac_item_t   in_data_reg;
    logic                 out_valid_reg;
    tac_pkg::tac_result_t out_data_reg;
    logic                 advance;
    tac_pkg::tac_cfg_t    cfg;
    tac_pkg::tac_result_t result;

    assign pready = 1'b1;

    tac_cfg_regs u_cfg_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // The held item moves on whenever the result register is free or drains.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    tac_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_data_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

>>> hdl/tac_checker.sv
// Port-level checks for the thermal alarm controller and their binding.
`include "thermal_alarm_controller_defines.svh"

module tac_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input tac_pkg::tac_result_t m_data
);

    // A stalled result holds its value.
    `TAC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // The input side only stalls behind a full, stalled output.
    `TAC_ASSERT_SAME(a_ready_stall, aclk, aresetn, !s_ready, m_valid && !m_ready)

    // Alarm mode drives only the red LED and stops sampling.
    `TAC_ASSERT_SAME(a_alarm_outputs, aclk, aresetn, m_valid && m_data.alarm, !m_data.led_green && !m_data.sampling_on)

    // A warning comes on the fourth phase change, which always lands in the on phase.
    `TAC_ASSERT_SAME(a_warn_phase, aclk, aresetn, m_valid && m_data.send_warning, m_data.alarm && m_data.led_red)

endmodule

bind thermal_alarm_controller tac_checker u_tac_checker (.*);

>>> tb/tac_status_check_pkg.sv
// Scoreboard class that predicts and checks the status reported for each accepted event.
package tac_status_check_pkg;

    import tac_pkg::*;

    class tac_status_scoreboard;

        // Register copy, as written over the configuration port.
        tac_cfg_t cfg;

        // Controller state as the block should hold it.
        bit                   alarm_mode;
        bit                   phase_on;
        int unsigned          phase_ms;
        bit [1:0]             toggles_since_warning;
        bit [SAMPLE_BITS-1:0] prev_sample;
        bit [SAMPLE_BITS-1:0] last_average;
        bit [TIME_W-1:0]      samples_left;
        bit                   sampling_active;
        bit [CHAR_W-1:0]      char_window [WINDOW_LEN];

        // Status words still owed by the block, oldest first.
        tac_result_t expected_status_q [$];

        int unsigned mismatches;
        int unsigned statuses_checked;
        int unsigned alarm_entries;
        int unsigned acknowledgements;
        int unsigned warnings;

        function new();
            cfg.alarm_threshold   = RST_ALARM_THRESHOLD;
            cfg.normal_on_ms      = RST_NORMAL_ON;
            cfg.normal_off_ms     = RST_NORMAL_OFF;
            cfg.alarm_on_ms       = RST_ALARM_ON;
            cfg.alarm_off_ms      = RST_ALARM_OFF;
            cfg.sample_budget     = RST_SAMPLE_BUDGET;
            toggles_since_warning = '0;
            prev_sample           = '0;
            last_average          = '0;
            foreach (char_window[i]) char_window[i] = '0;
            resume_normal();
        endfunction

        // Back to normal mode: LED phase restarts on and the sample budget reloads.
        function void resume_normal();
            alarm_mode      = 1'b0;
            phase_on        = 1'b1;
            phase_ms        = 0;
            samples_left    = cfg.sample_budget;
            sampling_active = 1'b1;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] data);
            case (idx)
                REG_ALARM_THRESHOLD: cfg.alarm_threshold = data[THRESH_W-1:0];
                REG_NORMAL_ON:       cfg.normal_on_ms    = data[TIME_W-1:0];
                REG_NORMAL_OFF:      cfg.normal_off_ms   = data[TIME_W-1:0];
                REG_ALARM_ON:        cfg.alarm_on_ms     = data[TIME_W-1:0];
                REG_ALARM_OFF:       cfg.alarm_off_ms    = data[TIME_W-1:0];
                REG_SAMPLE_BUDGET:   cfg.sample_budget   = data[TIME_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] reg_value(logic [2:0] idx);
            case (idx)
                REG_ALARM_THRESHOLD: return 32'(cfg.alarm_threshold);
                REG_NORMAL_ON:       return 32'(cfg.normal_on_ms);
                REG_NORMAL_OFF:      return 32'(cfg.normal_off_ms);
                REG_ALARM_ON:        return 32'(cfg.alarm_on_ms);
                REG_ALARM_OFF:       return 32'(cfg.alarm_off_ms);
                REG_SAMPLE_BUDGET:   return 32'(cfg.sample_budget);
                default:             return '0;
            endcase
        endfunction

        function int unsigned pending();
            return expected_status_q.size();
        endfunction

        // Advance the state by one accepted event and queue the status it must produce.
        function void note_event(tac_item_t ev);
            int unsigned duration;
            int unsigned avg;
            bit          warn;
            tac_result_t status;

            warn = 1'b0;
            case (ev.cmd)
                CMD_TICK: begin
                    if (alarm_mode)
                        duration = 32'(phase_on ? cfg.alarm_on_ms : cfg.alarm_off_ms);
                    else
                        duration = 32'(phase_on ? cfg.normal_on_ms : cfg.normal_off_ms);
                    // A zero duration behaves as one millisecond.
                    if (duration == 0)
                        duration = 1;
                    if (phase_ms + 1 >= duration) begin
                        phase_on = !phase_on;
                        phase_ms = 0;
                        // Every fourth toggle in alarm mode asks for a warning.
                        if (alarm_mode) begin
                            if (toggles_since_warning == 2'd3) begin
                                warn                  = 1'b1;
                                toggles_since_warning = '0;
                                warnings++;
                            end else begin
                                toggles_since_warning++;
                            end
                        end
                    end else begin
                        phase_ms++;
                    end
                end
                CMD_SAMPLE: begin
                    // Samples only count in normal mode while the budget lasts.
                    if (!alarm_mode && sampling_active) begin
                        avg          = (32'(ev.sample) + 32'(prev_sample)) >> 1;
                        prev_sample  = ev.sample;
                        last_average = SAMPLE_BITS'(avg);
                        if (avg > 32'(cfg.alarm_threshold)) begin
                            alarm_mode            = 1'b1;
                            phase_on              = 1'b1;
                            phase_ms              = 0;
                            toggles_since_warning = '0;
                            alarm_entries++;
                        end else begin
                            if (samples_left != 0)
                                samples_left--;
                            if (samples_left == 0)
                                sampling_active = 1'b0;
                        end
                    end
                end
                CMD_CHAR: begin
                    // Characters only shift in while the alarm is raised.
                    if (alarm_mode) begin
                        for (int i = 0; i < WINDOW_LEN - 1; i++)
                            char_window[i] = char_window[i+1];
                        char_window[WINDOW_LEN-1] = ev.rx_char;
                        if (char_window[0] == CH_A && char_window[1] == CH_C &&
                            char_window[2] == CH_K && char_window[3] == CH_BANG) begin
                            resume_normal();
                            acknowledgements++;
                        end
                    end
                end
                default: ;
            endcase

            status.alarm        = alarm_mode;
            status.led_green    = !alarm_mode && phase_on;
            status.led_red      = alarm_mode && phase_on;
            status.send_warning = warn;
            status.sampling_on  = !alarm_mode && sampling_active;
            status.average      = last_average;
            expected_status_q.push_back(status);
        endfunction

        function void compare_field(string name, logic [31:0] expv, logic [31:0] got);
            if (got !== expv) begin
                $error("%s: expected %0d, got %0d", name, expv, got);
                mismatches++;
            end
        endfunction

        // Compare one status transfer with the oldest outstanding prediction.
        function void check_status(tac_result_t got);
            tac_result_t expv;

            if (expected_status_q.size() == 0) begin
                $error("status transfer arrived with no event outstanding");
                mismatches++;
                return;
            end
            expv = expected_status_q.pop_front();
            compare_field("alarm", 32'(expv.alarm), 32'(got.alarm));
            compare_field("led_green", 32'(expv.led_green), 32'(got.led_green));
            compare_field("led_red", 32'(expv.led_red), 32'(got.led_red));
            compare_field("send_warning", 32'(expv.send_warning), 32'(got.send_warning));
            compare_field("sampling_on", 32'(expv.sampling_on), 32'(got.sampling_on));
            compare_field("average", 32'(expv.average), 32'(got.average));
            statuses_checked++;
        endfunction

    endclass

endpackage

>>> tb/tb_thermal_alarm_controller.sv
// Testbench top for the thermal alarm controller: stimulus, APB set-up and checking.
module tb_thermal_alarm_controller;

    timeunit 1ns;
    timeprecision 1ps;

    import tac_pkg::*;
    import tac_status_check_pkg::*;

    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int RANDOM_PHASES   = 8;
    localparam int EVENTS_PER_PHASE = 175;
    localparam int SETTLE_CYCLES   = 6;

    localparam logic [CMD_W-1:0] CMD_UNUSED       = 2'd3;
    localparam logic [2:0]       REG_FIRST_UNMAPPED = 3'd6;
    localparam logic [2:0]       REG_LAST_UNMAPPED  = 3'd7;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    tac_item_t   s_data  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    tac_result_t m_data;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr  = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic        pready;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned quiet_cycles   = 0;

    logic [CHAR_W-1:0] ack_seq [WINDOW_LEN] = '{CH_A, CH_C, CH_K, CH_BANG};
    string reg_names [6] = '{"alarm_threshold", "normal_on_ms", "normal_off_ms",
                             "alarm_on_ms", "alarm_off_ms", "sample_budget"};

    tac_status_scoreboard sb = new();

    thermal_alarm_controller dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Free-running clock, 8 ns period.
    initial begin
        forever #4 aclk = ~aclk;
    end

    // The result side stalls at random at the rate of the current phase.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Note every transfer on both channels and stop the run if all goes quiet.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_event(s_data);
            if (m_valid && m_ready)
                sb.check_status(m_data);
            if ((s_valid && s_ready) || (m_valid && m_ready) || psel) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    function automatic tac_item_t make_event(logic [CMD_W-1:0] cmd,
                                             logic [SAMPLE_BITS-1:0] smp,
                                             logic [CHAR_W-1:0] ch);
        tac_item_t ev;
        ev.cmd     = cmd;
        ev.sample  = smp;
        ev.rx_char = ch;
        return ev;
    endfunction

    // Offer one event, idling first at the sender's rate, and hold it until taken.
    task automatic send_event(input tac_item_t ev);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= ev;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_tick();
        send_event(make_event(CMD_TICK, SAMPLE_BITS'($urandom), CHAR_W'($urandom)));
    endtask

    task automatic send_sample(input logic [SAMPLE_BITS-1:0] smp);
        send_event(make_event(CMD_SAMPLE, smp, CHAR_W'($urandom)));
    endtask

    task automatic send_char(input logic [CHAR_W-1:0] ch);
        send_event(make_event(CMD_CHAR, SAMPLE_BITS'($urandom), ch));
    endtask

    // The acknowledge string, with one character spoilt when broken_at is in range.
    task automatic send_ack(input int broken_at);
        for (int i = 0; i < WINDOW_LEN; i++)
            send_char(i == broken_at ? CHAR_W'($urandom) : ack_seq[i]);
    endtask

    // Samples cluster at the extremes and around the threshold so alarms come often.
    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        int r;
        int v;
        r = $urandom_range(99);
        if (r < 15)
            return '0;
        if (r < 30)
            return '1;
        if (r < 60) begin
            v = int'(sb.cfg.alarm_threshold) + int'($urandom_range(60)) - 30;
            if (v < 0)
                v = 0;
            if (v > 1023)
                v = 1023;
            return SAMPLE_BITS'(v);
        end
        return SAMPLE_BITS'($urandom);
    endfunction

    // Register write with random upper data bits, which the block must discard.
    task automatic apb_write(input logic [2:0] idx, input logic [31:0] value, input int width);
        logic [31:0] noise;
        noise = $urandom;
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= (noise << width) | value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.write_reg(idx, pwdata);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_read_check(input logic [2:0] idx);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== sb.reg_value(idx)) begin
            $error("%s: expected %0d, got %0d", reg_names[idx], sb.reg_value(idx), prdata);
            sb.mismatches++;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write every register, poke an unmapped address, then read the set back.
    task automatic apply_config(input tac_cfg_t c);
        apb_write(REG_ALARM_THRESHOLD, 32'(c.alarm_threshold), THRESH_W);
        apb_write(REG_NORMAL_ON, 32'(c.normal_on_ms), TIME_W);
        apb_write(REG_NORMAL_OFF, 32'(c.normal_off_ms), TIME_W);
        apb_write(REG_ALARM_ON, 32'(c.alarm_on_ms), TIME_W);
        apb_write(REG_ALARM_OFF, 32'(c.alarm_off_ms), TIME_W);
        apb_write(REG_SAMPLE_BUDGET, 32'(c.sample_budget), TIME_W);
        apb_write(3'($urandom_range(REG_LAST_UNMAPPED, REG_FIRST_UNMAPPED)), $urandom, 0);
        for (int i = 0; i <= int'(REG_SAMPLE_BUDGET); i++)
            apb_read_check(3'(i));
    endtask

    // Stop offering events and wait until every status transfer has arrived.
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            1:       begin send_idle_pct = 58; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 58; end
            3:       begin send_idle_pct = 6;  recv_stall_pct = 6;  end
            default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    // Random traffic: tick bursts, samples, acknowledge strings (some spoilt) and noise.
    task automatic run_random(input int count);
        int sent;
        int r;
        int burst;
        sent = 0;
        while (sent < count) begin
            r = $urandom_range(99);
            if (r < 40) begin
                burst = $urandom_range(8, 1);
                repeat (burst) send_tick();
                sent += burst;
            end else if (r < 65) begin
                send_sample(pick_sample());
                sent++;
            end else if (r < 80) begin
                send_ack($urandom_range(99) < 20 ? int'($urandom_range(3)) : -1);
                sent += WINDOW_LEN;
            end else if (r < 95) begin
                if ($urandom_range(1))
                    send_char(ack_seq[$urandom_range(WINDOW_LEN - 1)]);
                else
                    send_char(CHAR_W'($urandom));
                sent++;
            end else begin
                send_event(make_event(CMD_UNUSED, SAMPLE_BITS'($urandom), CHAR_W'($urandom)));
                sent++;
            end
        end
    endtask

    function automatic tac_cfg_t phase_config(int phase);
        tac_cfg_t c;
        case (phase)
            // Shortest times, lowest threshold and a single-sample budget.
            0: begin
                c.alarm_threshold = '0;
                c.normal_on_ms    = 12'd1;
                c.normal_off_ms   = 12'd0;
                c.alarm_on_ms     = 12'd0;
                c.alarm_off_ms    = 12'd1;
                c.sample_budget   = 12'd1;
            end
            // Everything at its top value.
            1: begin
                c.alarm_threshold = '1;
                c.normal_on_ms    = '1;
                c.normal_off_ms   = '1;
                c.alarm_on_ms     = '1;
                c.alarm_off_ms    = '1;
                c.sample_budget   = '1;
            end
            default: begin
                c.alarm_threshold = THRESH_W'($urandom_range(900, 200));
                c.normal_on_ms    = TIME_W'($urandom_range(12));
                c.normal_off_ms   = TIME_W'($urandom_range(12));
                c.alarm_on_ms     = TIME_W'($urandom_range(12));
                c.alarm_off_ms    = TIME_W'($urandom_range(12));
                c.sample_budget   = TIME_W'($urandom_range(60));
            end
        endcase
        return c;
    endfunction

    initial begin
        tac_cfg_t c;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset values: averaging with truncation, entry into alarm, ignored
        // samples and characters, the unused command and an acknowledge.
        send_event(make_event(CMD_TICK, '1, '1));
        send_char(CH_A);
        send_event(make_event(CMD_SAMPLE, '0, '0));
        send_sample('1);
        send_sample(SAMPLE_BITS'(1022));
        send_sample('0);
        send_event(make_event(CMD_UNUSED, '1, '1));
        send_char(CH_C);
        send_ack(-1);
        drain();

        // Zero durations toggle on every tick; a two-sample budget runs out.
        c.alarm_threshold = '0;
        c.normal_on_ms    = '0;
        c.normal_off_ms   = '0;
        c.alarm_on_ms     = '0;
        c.alarm_off_ms    = '0;
        c.sample_budget   = 12'd2;
        apply_config(c);
        repeat (2) send_tick();
        send_sample('0);
        repeat (4) send_tick();
        send_ack(-1);
        send_sample('0);
        send_sample('0);
        send_sample('1);
        drain();

        // Random phases over a spread of settings and idling patterns.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            apply_config(phase_config(p));
            set_idling(p % 4);
            run_random(EVENTS_PER_PHASE);
            drain();
        end

        $display("Run covered %0d status transfers in %0d random phases after the directed set.",
                 sb.statuses_checked, RANDOM_PHASES);
        $display("Seen: %0d alarm entries, %0d acknowledgements, %0d warning requests.",
                 sb.alarm_entries, sb.acknowledgements, sb.warnings);
        if (sb.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/tac_pkg.sv
hdl/tac_cfg_regs.sv
hdl/tac_core.sv
hdl/thermal_alarm_controller.sv
hdl/tac_checker.sv
tb/tac_status_check_pkg.sv
tb/tb_thermal_alarm_controller.sv
